@@ hdl/blob_run_moment_accumulator_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef BLOB_RUN_MOMENT_ACCUMULATOR_CORE_MACROS_SVH
`define BLOB_RUN_MOMENT_ACCUMULATOR_CORE_MACROS_SVH

// Clocked property, masked while reset is asserted
`define BRMAC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("brmac check failed");

// Clocked property that must also hold while reset is asserted
`define BRMAC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("brmac check failed during or after reset");

`endif

@@ hdl/brmac_pkg.sv @@
package brmac_pkg;

	// Default geometry
	localparam int COORD_BITS_DEF = 12;
	localparam int LABEL_BITS_DEF = 16;

	// Accumulator widths, fixed by the result format
	localparam int CNT_W = 25;
	localparam int SUM_W = 48;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Run opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_ADD   = 1'b1;

	// Per-run control travelling from front to back
	typedef struct packed {
		logic start;
		logic bad;
	} brmac_ctl_t;

endpackage

@@ hdl/brmac_front.sv @@
// Front end: accepts runs, classifies them and works out the run moments
// over a four-stage pipeline. All stages advance together.
module brmac_front import brmac_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int LABEL_BITS = LABEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  op,
	input  logic [LABEL_BITS-1:0] blob_label,
	input  logic [COORD_BITS-1:0] x_first,
	input  logic [COORD_BITS-1:0] x_last,
	input  logic [COORD_BITS-1:0] row,
	output logic                  run_valid,
	input  logic                  run_ready,
	output brmac_ctl_t            run_ctl,
	output logic [LABEL_BITS-1:0] run_label,
	output logic [COORD_BITS-1:0] run_xa,
	output logic [COORD_BITS-1:0] run_xb,
	output logic [COORD_BITS-1:0] run_y,
	output logic [CNT_W-1:0]      run_n,
	output logic [SUM_W-1:0]      run_xs,
	output logic [SUM_W-1:0]      run_ys,
	output logic [SUM_W-1:0]      run_xy,
	output logic [SUM_W-1:0]      run_xx,
	output logic [SUM_W-1:0]      run_yy
);

	localparam int CW = COORD_BITS;
	localparam int FW = CW + 1;
	// Inverse of 3 modulo 2^FW, and the largest quotient of an exact multiple
	localparam logic [FW-1:0] INV3 = FW'(((FW % 2) == 1) ?
		((64'd1 << FW) + 64'd1) / 64'd3 : ((64'd1 << (FW + 1)) + 64'd1) / 64'd3);
	localparam logic [FW-1:0] LIM3 = FW'(((64'd1 << FW) - 64'd1) / 64'd3);

	// Factors of k(k+1)(2k+1)/6 with the /6 already folded in:
	// the one factor divisible by 3 is divided exactly, the even one halved.
	function automatic logic [3*CW+1:0] sq_factors(input logic [CW-1:0] k);
		logic [FW-1:0] fa;
		logic [FW-1:0] fb;
		logic [FW-1:0] fc;
		logic [FW-1:0] qa;
		logic [FW-1:0] qb;
		logic [FW-1:0] qc;
		fa = {1'b0, k};
		fb = fa + 1'b1;
		fc = {k, 1'b1};
		qa = FW'(fa * INV3);
		qb = FW'(fb * INV3);
		qc = FW'(fc * INV3);
		if (qa <= LIM3) begin
			fa = qa;
		end else if (qb <= LIM3) begin
			fb = qb;
		end else begin
			fc = qc;
		end
		if (k[0] == 1'b0) begin
			fa = fa >> 1;
		end else begin
			fb = fb >> 1;
		end
		return {fa[CW-1:0], fb, fc};
	endfunction

	logic advance;

	// stage 1
	logic                  v_s1, start_s1, bad_s1;
	logic [LABEL_BITS-1:0] label_s1;
	logic [CW-1:0]         xa_s1, xb_s1, y_s1;
	logic [CW:0]           n_s1, sxy_s1;
	// stage 2
	logic                  v_s2, start_s2, bad_s2, kz_s2;
	logic [LABEL_BITS-1:0] label_s2;
	logic [CW-1:0]         xa_s2, xb_s2, y_s2;
	logic [CW:0]           n_s2;
	logic [3*CW+1:0]       fac1_s2, fac0_s2;
	logic [2*CW+1:0]       nsx_s2;
	logic [2*CW:0]         yn_s2;
	logic [2*CW-1:0]       ysq_s2;
	// stage 3
	logic                  v_s3, start_s3, bad_s3, kz_s3;
	logic [LABEL_BITS-1:0] label_s3;
	logic [CW-1:0]         xa_s3, xb_s3, y_s3;
	logic [CW:0]           n_s3;
	logic [2*CW:0]         xs_s3, ys_s3;
	logic [3*CW:0]         xy_s3, yy_s3;
	logic [2*CW:0]         ab1_s3, ab0_s3;
	logic [CW:0]           fc1_s3, fc0_s3;
	// stage 4
	logic                  v_s4, start_s4, bad_s4;
	logic [LABEL_BITS-1:0] label_s4;
	logic [CW-1:0]         xa_s4, xb_s4, y_s4;
	logic [CW:0]           n_s4;
	logic [2*CW:0]         xs_s4, ys_s4;
	logic [3*CW:0]         xy_s4, yy_s4;
	logic [3*CW+1:0]       sq1_s4, sq0_s4;

	// whole pipeline moves unless the last stage is blocked
	assign advance  = !v_s4 || run_ready;
	assign in_ready = advance;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: classify, run length and end-point sum
	always_ff @(posedge clk) begin
		if (advance) begin
			start_s1 <= (op == OP_START);
			bad_s1   <= (x_last < x_first);
			label_s1 <= blob_label;
			xa_s1    <= x_first;
			xb_s1    <= x_last;
			y_s1     <= row;
			n_s1     <= {1'b0, x_last} - {1'b0, x_first} + 1'b1;
			sxy_s1   <= {1'b0, x_first} + {1'b0, x_last};
		end
	end

	// stage 2: first products and sum-of-squares factors
	always_ff @(posedge clk) begin
		if (advance) begin
			start_s2 <= start_s1;
			bad_s2   <= bad_s1;
			label_s2 <= label_s1;
			xa_s2    <= xa_s1;
			xb_s2    <= xb_s1;
			y_s2     <= y_s1;
			n_s2     <= n_s1;
			kz_s2    <= (xa_s1 == '0);
			fac1_s2  <= sq_factors(xb_s1);
			fac0_s2  <= sq_factors(xa_s1 - 1'b1);
			nsx_s2   <= n_s1 * sxy_s1;
			yn_s2    <= y_s1 * n_s1;
			ysq_s2   <= y_s1 * y_s1;
		end
	end

	// stage 3: x sum, cross and y-squared terms, first factor products
	always_ff @(posedge clk) begin
		if (advance) begin
			start_s3 <= start_s2;
			bad_s3   <= bad_s2;
			label_s3 <= label_s2;
			xa_s3    <= xa_s2;
			xb_s3    <= xb_s2;
			y_s3     <= y_s2;
			n_s3     <= n_s2;
			kz_s3    <= kz_s2;
			xs_s3    <= nsx_s2[2*CW+1:1];
			ys_s3    <= yn_s2;
			xy_s3    <= y_s2 * nsx_s2[2*CW+1:1];
			yy_s3    <= ysq_s2 * n_s2;
			ab1_s3   <= fac1_s2[3*CW+1:2*CW+2] * fac1_s2[2*CW+1:CW+1];
			ab0_s3   <= fac0_s2[3*CW+1:2*CW+2] * fac0_s2[2*CW+1:CW+1];
			fc1_s3   <= fac1_s2[CW:0];
			fc0_s3   <= fac0_s2[CW:0];
		end
	end

	// stage 4: sums of squares up to each end of the run
	always_ff @(posedge clk) begin
		if (advance) begin
			start_s4 <= start_s3;
			bad_s4   <= bad_s3;
			label_s4 <= label_s3;
			xa_s4    <= xa_s3;
			xb_s4    <= xb_s3;
			y_s4     <= y_s3;
			n_s4     <= n_s3;
			xs_s4    <= xs_s3;
			ys_s4    <= ys_s3;
			xy_s4    <= xy_s3;
			yy_s4    <= yy_s3;
			sq1_s4   <= ab1_s3 * fc1_s3;
			sq0_s4   <= kz_s3 ? '0 : ab0_s3 * fc0_s3;
		end
	end

	// beat towards the queue
	assign run_valid     = v_s4;
	assign run_ctl.start = start_s4;
	assign run_ctl.bad   = bad_s4;
	assign run_label     = label_s4;
	assign run_xa        = xa_s4;
	assign run_xb        = xb_s4;
	assign run_y         = y_s4;
	assign run_n         = CNT_W'(n_s4);
	assign run_xs        = SUM_W'(xs_s4);
	assign run_ys        = SUM_W'(ys_s4);
	assign run_xy        = SUM_W'(xy_s4);
	assign run_yy        = SUM_W'(yy_s4);
	assign run_xx        = SUM_W'(sq1_s4 - sq0_s4);

endmodule

@@ hdl/brmac_queue.sv @@
// Small FIFO between front and back.
module brmac_queue import brmac_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CTW-1:0]   count_q;
	logic             push, pop;

	assign push_ready = (count_q != CTW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/brmac_back.sv @@
// Back end: folds one run beat a cycle into the blob totals while no
// result is stalled, and holds the result until it is taken.
module brmac_back import brmac_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int LABEL_BITS = LABEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  run_valid,
	output logic                  run_ready,
	input  brmac_ctl_t            run_ctl,
	input  logic [LABEL_BITS-1:0] run_label,
	input  logic [COORD_BITS-1:0] run_xa,
	input  logic [COORD_BITS-1:0] run_xb,
	input  logic [COORD_BITS-1:0] run_y,
	input  logic [CNT_W-1:0]      run_n,
	input  logic [SUM_W-1:0]      run_xs,
	input  logic [SUM_W-1:0]      run_ys,
	input  logic [SUM_W-1:0]      run_xy,
	input  logic [SUM_W-1:0]      run_xx,
	input  logic [SUM_W-1:0]      run_yy,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LABEL_BITS-1:0] cur_label,
	output logic [CNT_W-1:0]      area,
	output logic [SUM_W-1:0]      sum_x,
	output logic [SUM_W-1:0]      sum_y,
	output logic [SUM_W-1:0]      sum_xy,
	output logic [SUM_W-1:0]      sum_xx,
	output logic [SUM_W-1:0]      sum_yy,
	output logic [COORD_BITS-1:0] box_min_x,
	output logic [COORD_BITS-1:0] box_max_x,
	output logic [COORD_BITS-1:0] box_min_y,
	output logic [COORD_BITS-1:0] box_max_y,
	output logic                  bad_run
);

	logic                  valid_q, bad_q;
	logic [LABEL_BITS-1:0] label_q;
	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      xsum_q, ysum_q, xysum_q, xxsum_q, yysum_q;
	logic [COORD_BITS-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic                  take;

	// the totals double as the result register, so a beat is taken only
	// when the previous result has gone
	assign run_ready = !valid_q || out_ready;
	assign take      = run_valid && run_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			bad_q   <= 1'b0;
			label_q <= '0;
			count_q <= '0;
			xsum_q  <= '0;
			ysum_q  <= '0;
			xysum_q <= '0;
			xxsum_q <= '0;
			yysum_q <= '0;
			min_x_q <= '0;
			max_x_q <= '0;
			min_y_q <= '0;
			max_y_q <= '0;
		end else if (take) begin
			valid_q <= 1'b1;
			bad_q   <= run_ctl.bad;
			// reversed run: totals untouched
			if (!run_ctl.bad) begin
				if (run_ctl.start) begin
					label_q <= run_label;
					count_q <= run_n;
					xsum_q  <= run_xs;
					ysum_q  <= run_ys;
					xysum_q <= run_xy;
					xxsum_q <= run_xx;
					yysum_q <= run_yy;
					min_x_q <= run_xa;
					max_x_q <= run_xb;
					min_y_q <= run_y;
					max_y_q <= run_y;
				end else begin
					count_q <= count_q + run_n;
					xsum_q  <= xsum_q + run_xs;
					ysum_q  <= ysum_q + run_ys;
					xysum_q <= xysum_q + run_xy;
					xxsum_q <= xxsum_q + run_xx;
					yysum_q <= yysum_q + run_yy;
					if (run_xa < min_x_q) min_x_q <= run_xa;
					if (run_xb > max_x_q) max_x_q <= run_xb;
					if (run_y < min_y_q) min_y_q <= run_y;
					if (run_y > max_y_q) max_y_q <= run_y;
				end
			end
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign bad_run   = bad_q;
	assign cur_label = label_q;
	assign area      = count_q;
	assign sum_x     = xsum_q;
	assign sum_y     = ysum_q;
	assign sum_xy    = xysum_q;
	assign sum_xx    = xxsum_q;
	assign sum_yy    = yysum_q;
	assign box_min_x = min_x_q;
	assign box_max_x = max_x_q;
	assign box_min_y = min_y_q;
	assign box_max_y = max_y_q;

endmodule

@@ hdl/blob_run_moment_accumulator_core.sv @@
// A run passes the four front stages, the queue and the totals register.
// Throughput: one run per cycle with the output free; the four-stage moment
// pipeline and the accumulate stage both take a beat every cycle.
// An output stall fills the two-entry queue, then holds the front and in_ready.
// Reset (arst_n low, asynchronous): label, totals, box and all valid flags clear.
module blob_run_moment_accumulator_core import brmac_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int LABEL_BITS = LABEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  op,
	input  logic [LABEL_BITS-1:0] blob_label,
	input  logic [COORD_BITS-1:0] x_first,
	input  logic [COORD_BITS-1:0] x_last,
	input  logic [COORD_BITS-1:0] row,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LABEL_BITS-1:0] cur_label,
	output logic [CNT_W-1:0]      area,
	output logic [SUM_W-1:0]      sum_x,
	output logic [SUM_W-1:0]      sum_y,
	output logic [SUM_W-1:0]      sum_xy,
	output logic [SUM_W-1:0]      sum_xx,
	output logic [SUM_W-1:0]      sum_yy,
	output logic [COORD_BITS-1:0] box_min_x,
	output logic [COORD_BITS-1:0] box_max_x,
	output logic [COORD_BITS-1:0] box_min_y,
	output logic [COORD_BITS-1:0] box_max_y,
	output logic                  bad_run
);

	localparam int QW = $bits(brmac_ctl_t) + LABEL_BITS + 3 * COORD_BITS + CNT_W + 5 * SUM_W;

	// front side of the queue
	logic                  f_valid, f_ready;
	brmac_ctl_t            f_ctl;
	logic [LABEL_BITS-1:0] f_label;
	logic [COORD_BITS-1:0] f_xa, f_xb, f_y;
	logic [CNT_W-1:0]      f_n;
	logic [SUM_W-1:0]      f_xs, f_ys, f_xy, f_xx, f_yy;
	// back side of the queue
	logic                  b_valid, b_ready;
	brmac_ctl_t            b_ctl;
	logic [LABEL_BITS-1:0] b_label;
	logic [COORD_BITS-1:0] b_xa, b_xb, b_y;
	logic [CNT_W-1:0]      b_n;
	logic [SUM_W-1:0]      b_xs, b_ys, b_xy, b_xx, b_yy;
	logic [QW-1:0]         push_word, pop_word;

	brmac_front #(
		.COORD_BITS(COORD_BITS),
		.LABEL_BITS(LABEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.blob_label(blob_label),
		.x_first   (x_first),
		.x_last    (x_last),
		.row       (row),
		.run_valid (f_valid),
		.run_ready (f_ready),
		.run_ctl   (f_ctl),
		.run_label (f_label),
		.run_xa    (f_xa),
		.run_xb    (f_xb),
		.run_y     (f_y),
		.run_n     (f_n),
		.run_xs    (f_xs),
		.run_ys    (f_ys),
		.run_xy    (f_xy),
		.run_xx    (f_xx),
		.run_yy    (f_yy)
	);

	// pack and unpack the queued beat
	assign push_word = {f_ctl, f_label, f_xa, f_xb, f_y, f_n, f_xs, f_ys, f_xy, f_xx, f_yy};
	assign {b_ctl, b_label, b_xa, b_xb, b_y, b_n, b_xs, b_ys, b_xy, b_xx, b_yy} = pop_word;

	brmac_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (push_word),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (pop_word)
	);

	brmac_back #(
		.COORD_BITS(COORD_BITS),
		.LABEL_BITS(LABEL_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.run_valid(b_valid),
		.run_ready(b_ready),
		.run_ctl  (b_ctl),
		.run_label(b_label),
		.run_xa   (b_xa),
		.run_xb   (b_xb),
		.run_y    (b_y),
		.run_n    (b_n),
		.run_xs   (b_xs),
		.run_ys   (b_ys),
		.run_xy   (b_xy),
		.run_xx   (b_xx),
		.run_yy   (b_yy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cur_label(cur_label),
		.area     (area),
		.sum_x    (sum_x),
		.sum_y    (sum_y),
		.sum_xy   (sum_xy),
		.sum_xx   (sum_xx),
		.sum_yy   (sum_yy),
		.box_min_x(box_min_x),
		.box_max_x(box_max_x),
		.box_min_y(box_min_y),
		.box_max_y(box_max_y),
		.bad_run  (bad_run)
	);

endmodule

@@ hdl/brmac_checker.sv @@
`include "blob_run_moment_accumulator_core_macros.svh"

// Port-level checks on the result channel.
module brmac_checker import brmac_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int LABEL_BITS = LABEL_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [LABEL_BITS-1:0] cur_label,
	input logic [CNT_W-1:0]      area,
	input logic [SUM_W-1:0]      sum_xx,
	input logic [COORD_BITS-1:0] box_min_x,
	input logic [COORD_BITS-1:0] box_max_x,
	input logic [COORD_BITS-1:0] box_min_y,
	input logic [COORD_BITS-1:0] box_max_y,
	input logic                  bad_run
);

	// a stalled result beat stays offered
	`BRMAC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

	// and keeps its area, sum_xx, label and bad_run
	`BRMAC_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(area) && $stable(sum_xx) && $stable(cur_label) && $stable(bad_run))

	// the box is never inverted
	`BRMAC_ASSERT(a_box_order, out_valid |-> box_min_x <= box_max_x && box_min_y <= box_max_y)

	// nothing is offered while reset is held
	`BRMAC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid)

endmodule

bind blob_run_moment_accumulator_core brmac_checker #(
	.COORD_BITS(COORD_BITS),
	.LABEL_BITS(LABEL_BITS)
) u_brmac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.cur_label(cur_label),
	.area     (area),
	.sum_xx   (sum_xx),
	.box_min_x(box_min_x),
	.box_max_x(box_max_x),
	.box_min_y(box_min_y),
	.box_max_y(box_max_y),
	.bad_run  (bad_run)
);

@@ tb/sv/tb_blob_run_moment_accumulator_core.sv @@
`timescale 1ns / 100ps

module tb_blob_run_moment_accumulator_core import brmac_pkg::*; ();

	localparam int CW = COORD_BITS_DEF;
	localparam int LW = LABEL_BITS_DEF;
	localparam int COORD_MAX = (1 << CW) - 1;

	// One run beat as offered to the block
	typedef struct packed {
		logic          op;
		logic [LW-1:0] blob_label;
		logic [CW-1:0] x_first;
		logic [CW-1:0] x_last;
		logic [CW-1:0] row;
	} run_t;

	// Blob totals as returned after every run
	typedef struct packed {
		logic [LW-1:0]    lab;
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] sx;
		logic [SUM_W-1:0] sy;
		logic [SUM_W-1:0] sxy;
		logic [SUM_W-1:0] sxx;
		logic [SUM_W-1:0] syy;
		logic [CW-1:0]    min_x;
		logic [CW-1:0]    max_x;
		logic [CW-1:0]    min_y;
		logic [CW-1:0]    max_y;
		logic             bad;
	} moments_t;

	// Directed row: run, plus totals typed in by hand where obvious
	typedef struct packed {
		run_t     run;
		logic     typed;
		moments_t want;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             op = OP_START;
	logic [LW-1:0]    blob_label = '0;
	logic [CW-1:0]    x_first = '0;
	logic [CW-1:0]    x_last = '0;
	logic [CW-1:0]    row = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [LW-1:0]    cur_label;
	logic [CNT_W-1:0] area;
	logic [SUM_W-1:0] sum_x;
	logic [SUM_W-1:0] sum_y;
	logic [SUM_W-1:0] sum_xy;
	logic [SUM_W-1:0] sum_xx;
	logic [SUM_W-1:0] sum_yy;
	logic [CW-1:0]    box_min_x;
	logic [CW-1:0]    box_max_x;
	logic [CW-1:0]    box_min_y;
	logic [CW-1:0]    box_max_y;
	logic             bad_run;

	moments_t    blob_tot = '0;
	moments_t    moment_q[$];
	dir_row_t    dir_tab[$];
	int unsigned err_cnt = 0;

	// Idling controls, written by the stimulus process only
	int unsigned tx_gap_pct = 0;
	int unsigned rx_stall_pct = 0;
	bit          quiet = 1'b0;
	int unsigned hold_reqs = 0;

	// Receiver-side counters
	int unsigned hold_seen = 0;
	int unsigned rx_hold_left = 0;
	int unsigned rx_idle_left = 0;

	blob_run_moment_accumulator_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.blob_label (blob_label),
		.x_first    (x_first),
		.x_last     (x_last),
		.row        (row),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cur_label  (cur_label),
		.area       (area),
		.sum_x      (sum_x),
		.sum_y      (sum_y),
		.sum_xy     (sum_xy),
		.sum_xx     (sum_xx),
		.sum_yy     (sum_yy),
		.box_min_x  (box_min_x),
		.box_max_x  (box_max_x),
		.box_min_y  (box_min_y),
		.box_max_y  (box_max_y),
		.bad_run    (bad_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic run_t mk_run(input logic o, input logic [LW-1:0] lb,
			input int unsigned xa, input int unsigned xb, input int unsigned y);
		run_t r;
		r.op = o;
		r.blob_label = lb;
		r.x_first = CW'(xa);
		r.x_last = CW'(xb);
		r.row = CW'(y);
		return r;
	endfunction

	function automatic moments_t mk_res(input logic [LW-1:0] lb, input longint unsigned c,
			input longint unsigned s_x, input longint unsigned s_y,
			input longint unsigned s_xy, input longint unsigned s_xx,
			input longint unsigned s_yy, input int unsigned x0, input int unsigned x1,
			input int unsigned y0, input int unsigned y1, input logic b);
		moments_t m;
		m.lab = lb;
		m.cnt = CNT_W'(c);
		m.sx = SUM_W'(s_x);
		m.sy = SUM_W'(s_y);
		m.sxy = SUM_W'(s_xy);
		m.sxx = SUM_W'(s_xx);
		m.syy = SUM_W'(s_yy);
		m.min_x = CW'(x0);
		m.max_x = CW'(x1);
		m.min_y = CW'(y0);
		m.max_y = CW'(y1);
		m.bad = b;
		return m;
	endfunction

	// Append a directed row to the table
	function automatic void add_row(input run_t r, input logic typed, input moments_t want);
		dir_row_t d;
		d.run = r;
		d.typed = typed;
		d.want = want;
		dir_tab.insert(dir_tab.size(), d);
	endfunction

	// Append a predicted result to the tail of the queue
	function automatic void note_result(input moments_t m);
		moment_q.insert(moment_q.size(), m);
	endfunction

	// 1^2 + 2^2 + ... + k^2
	function automatic longint unsigned squares_to(input longint unsigned k);
		return k * (k + 1) * (2 * k + 1) / 6;
	endfunction

	// Fold one run into the predicted blob totals and return what the block should show
	function automatic moments_t accumulate_run(input run_t r);
		longint unsigned xa, xb, yv, n, xs, xx, ys, xy, yy;
		moments_t res;
		xa = r.x_first;
		xb = r.x_last;
		yv = r.row;
		// reversed run: totals untouched, label not taken
		if (xb < xa) begin
			res = blob_tot;
			res.bad = 1'b1;
			return res;
		end
		n = xb - xa + 1;
		xs = n * (xa + xb) / 2;
		xx = squares_to(xb) - ((xa == 0) ? 64'd0 : squares_to(xa - 1));
		ys = yv * n;
		xy = yv * xs;
		yy = yv * yv * n;
		if (r.op == OP_START) begin
			blob_tot.lab = r.blob_label;
			blob_tot.cnt = CNT_W'(n);
			blob_tot.sx = SUM_W'(xs);
			blob_tot.sy = SUM_W'(ys);
			blob_tot.sxy = SUM_W'(xy);
			blob_tot.sxx = SUM_W'(xx);
			blob_tot.syy = SUM_W'(yy);
			blob_tot.min_x = r.x_first;
			blob_tot.max_x = r.x_last;
			blob_tot.min_y = r.row;
			blob_tot.max_y = r.row;
		end else begin
			// plain adders: wrap at their widths
			blob_tot.cnt = blob_tot.cnt + CNT_W'(n);
			blob_tot.sx = blob_tot.sx + SUM_W'(xs);
			blob_tot.sy = blob_tot.sy + SUM_W'(ys);
			blob_tot.sxy = blob_tot.sxy + SUM_W'(xy);
			blob_tot.sxx = blob_tot.sxx + SUM_W'(xx);
			blob_tot.syy = blob_tot.syy + SUM_W'(yy);
			if (r.x_first < blob_tot.min_x) blob_tot.min_x = r.x_first;
			if (r.x_last > blob_tot.max_x) blob_tot.max_x = r.x_last;
			if (r.row < blob_tot.min_y) blob_tot.min_y = r.row;
			if (r.row > blob_tot.max_y) blob_tot.max_y = r.row;
		end
		blob_tot.bad = 1'b0;
		return blob_tot;
	endfunction

	// Offer one run, maybe after a sender gap; valid stays up after the beat
	task automatic send_run(input run_t r, input logic typed, input moments_t want);
		moments_t pred;
		if (!quiet && tx_gap_pct != 0 && $urandom_range(99, 0) < tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= r.op;
		blob_label <= r.blob_label;
		x_first <= r.x_first;
		x_last <= r.x_last;
		row <= r.row;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = accumulate_run(r);
		note_result(typed ? want : pred);
	endtask

	// Mostly well-formed blobs (a start then a few adds on nearby rows), some noise
	task automatic random_blobs(input int unsigned n_items);
		int unsigned sent, adds, w, xa, y0, i;
		logic [LW-1:0] lab;
		run_t r;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9, 0) == 0) begin
				r = mk_run(1'($urandom_range(1, 0)), LW'($urandom),
					$urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
					$urandom_range(COORD_MAX, 0));
				send_run(r, 1'b0, '0);
				sent++;
			end else begin
				lab = LW'($urandom);
				y0 = $urandom_range(COORD_MAX, 0);
				adds = $urandom_range(12, 0);
				for (i = 0; i <= adds; i++) begin
					w = ($urandom_range(3, 0) == 0) ? $urandom_range(COORD_MAX, 0)
						: $urandom_range(63, 0);
					xa = $urandom_range(COORD_MAX - w, 0);
					r = mk_run((i == 0) ? OP_START : OP_ADD,
						(i == 0) ? lab : LW'($urandom), xa, xa + w,
						$urandom_range(1, 0) ? (y0 + i) : (y0 - i));
					// now and then a reversed run inside the blob
					if (w != 0 && $urandom_range(15, 0) == 0) begin
						r.x_first = CW'(xa + w);
						r.x_last = CW'(xa);
					end
					send_run(r, 1'b0, '0);
					sent++;
				end
			end
		end
	endtask

	// Receiver: random stall bursts, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			rx_hold_left = 80;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (rx_idle_left != 0) begin
			rx_idle_left--;
			out_ready <= 1'b0;
		end else if (!quiet && rx_stall_pct != 0 && $urandom_range(99, 0) < rx_stall_pct) begin
			rx_idle_left = $urandom_range(14, 0);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic chk(input string fld, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", fld, want, got);
			err_cnt++;
		end
	endtask

	// Result beats are checked in arrival order against the predicted totals
	always @(posedge clk) begin : result_check
		moments_t want;
		if (arst_n && out_valid && out_ready) begin
			if (moment_q.size() == 0) begin
				$error("result beat with no run outstanding");
				err_cnt++;
			end else begin
				want = moment_q.pop_front();
				chk("cur_label", want.lab, cur_label);
				chk("area", want.cnt, area);
				chk("sum_x", want.sx, sum_x);
				chk("sum_y", want.sy, sum_y);
				chk("sum_xy", want.sxy, sum_xy);
				chk("sum_xx", want.sxx, sum_xx);
				chk("sum_yy", want.syy, sum_yy);
				chk("box_min_x", want.min_x, box_min_x);
				chk("box_max_x", want.max_x, box_max_x);
				chk("box_min_y", want.min_y, box_min_y);
				chk("box_max_y", want.max_y, box_max_y);
				chk("bad_run", want.bad, bad_run);
			end
		end
	end

	// Stimulus
	initial begin
		// reset goes low at the start so the block sees a real falling edge
		arst_n <= 1'b0;

		// reversed runs straight after reset leave the empty blob as is
		add_row(mk_run(OP_ADD, 16'h0000, 9, 3, 0), 1'b1,
			mk_res(16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
		add_row(mk_run(OP_START, 16'hFFFF, 4095, 0, 4095), 1'b1,
			mk_res(16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
		// add before any start: merged into the zero box, minima stay at 0
		add_row(mk_run(OP_ADD, 16'h1234, 5, 7, 3), 1'b1,
			mk_res(16'h0000, 3, 18, 9, 54, 110, 27, 0, 7, 0, 3, 1'b0));
		// single pixels at the corners
		add_row(mk_run(OP_START, 16'hFFFF, 0, 0, 0), 1'b1,
			mk_res(16'hFFFF, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
		add_row(mk_run(OP_START, 16'h0000, 4095, 4095, 4095), 1'b1,
			mk_res(16'h0000, 1, 4095, 4095, 16769025, 16769025, 16769025,
				4095, 4095, 4095, 4095, 1'b0));
		add_row(mk_run(OP_ADD, 16'hFFFF, 0, 4095, 0), 1'b0, moments_t'('0));
		add_row(mk_run(OP_ADD, 16'h0F0F, 4095, 4094, 7), 1'b0, moments_t'('0));
		add_row(mk_run(OP_START, 16'h5A5A, 0, 4095, 4095), 1'b0, moments_t'('0));
		add_row(mk_run(OP_ADD, 16'h0000, 0, 0, 0), 1'b0, moments_t'('0));
		add_row(mk_run(OP_START, 16'hA5A5, 100, 100, 2048), 1'b0, moments_t'('0));
		add_row(mk_run(OP_ADD, 16'h0000, 99, 101, 2047), 1'b0, moments_t'('0));
		add_row(mk_run(OP_ADD, 16'h0000, 0, 4095, 4095), 1'b0, moments_t'('0));
		add_row(mk_run(OP_ADD, 16'h0000, 2048, 2048, 2049), 1'b0, moments_t'('0));
		add_row(mk_run(OP_START, 16'h0001, 0, 1, 1), 1'b0, moments_t'('0));
		add_row(mk_run(OP_ADD, 16'h0000, 1, 0, 1), 1'b0, moments_t'('0));
		// reversed start must not take the label
		add_row(mk_run(OP_START, 16'h8000, 2730, 1365, 1), 1'b0, moments_t'('0));
		add_row(mk_run(OP_ADD, 16'h0000, 1365, 2730, 2730), 1'b0, moments_t'('0));
		add_row(mk_run(OP_START, 16'h7FFF, 4094, 4095, 1), 1'b0, moments_t'('0));
		add_row(mk_run(OP_ADD, 16'h0000, 1, 4094, 4094), 1'b0, moments_t'('0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		tx_gap_pct = 30;
		rx_stall_pct = 30;
		foreach (dir_tab[i]) send_run(dir_tab[i].run, dir_tab[i].typed, dir_tab[i].want);

		random_blobs(240);
		// unbroken stretch
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		random_blobs(90);
		// long receiver hold-off while runs keep coming, so the input stalls
		hold_reqs++;
		random_blobs(30);
		// sender pause until the block has drained
		in_valid <= 1'b0;
		while (moment_q.size() != 0) @(posedge clk);
		tx_gap_pct = 10;
		rx_stall_pct = 60;
		random_blobs(200);
		tx_gap_pct = 60;
		rx_stall_pct = 10;
		random_blobs(220);

		// last part, no idling: full rows on the bottom line, back to back
		quiet = 1'b1;
		send_run(mk_run(OP_START, 16'hC3C3, 0, 4095, 4095), 1'b0, '0);
		repeat (40) send_run(mk_run(OP_ADD, LW'($urandom), 0, 4095, 4095), 1'b0, '0);

		in_valid <= 1'b0;
		while (moment_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0) begin
			$display("[blob_run_moment_accumulator_core] OK");
		end else begin
			$display("[blob_run_moment_accumulator_core] ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("[blob_run_moment_accumulator_core] ERROR");
		$finish;
	end

endmodule
